[rtl/smva_pkg.sv]
package smva_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned FRAC_W = 16;

  localparam int unsigned VECTOR_DEPTH_DEF = 1024;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = VAL_W;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 2'd2;

  localparam logic signed [VAL_W-1:0] SCALE_RESET = 32'sd65536;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REQ_LOAD_VEC = 2'd0,
    REQ_LOAD_RES = 2'd1,
    REQ_NONZERO  = 2'd2,
    REQ_READ     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OP_VEC_WR  = 2'd0,
    OP_RES_WR  = 2'd1,
    OP_NONZERO = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_MUL1 = 2'd2,
    ST_MUL2 = 2'd3
  } st_e;

  typedef struct packed {
    req_e                    req_type;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        column_index;
    logic signed [VAL_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
  } out_item_t;

  typedef struct packed {
    op_e                     op;
    logic                    idx_ok;
    logic [IDX_W-1:0]        src;
    logic [IDX_W-1:0]        dst;
    logic signed [VAL_W-1:0] data;
  } cmd_t;

  // saturate a wide signed value to the q16.16 range
  function automatic logic signed [VAL_W-1:0] sat_q(input logic signed [PROD_W-FRAC_W-1:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > (PROD_W-FRAC_W)'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (x < (PROD_W-FRAC_W)'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/sparse_matrix_vector_accumulate.sv]
// sparse matrix-vector accumulate engine
// input queue: drive in_item_i with push high; the item is taken at a rising
// edge where full is low. req_type selects load of an operand element,
// preload of a result element, one matrix nonzero, or a result read.
// result queue: while empty is low the oldest read result is on out_item_o;
// it is taken at a rising edge where pop is high.
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 scale,
// 1 subtract, 2 transpose); write only while no item is in flight.
// a front stage classifies items into a 4-entry command queue; a back
// sequencer executes them one at a time against two single-port-write rams.
// in the back, a nonzero takes two passes through one shared 32x32
// multiplier plus the result read-modify-write; a read passes through the
// command queue, the result ram and the result register before empty falls.
// stalls on pop hold the result register; the back then waits on further
// reads, and once the command queue fills, full rises.
// reset clears both queues and the config registers (scale 1.0); ram contents
// are not cleared, so entries must be written before they are read.
module sparse_matrix_vector_accumulate
  import smva_pkg::*;
#(
  parameter int unsigned VectorDepth = VECTOR_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic signed [VAL_W-1:0] scale_q;
  logic subtract_q, transpose_q;

  logic cmd_valid, cmd_pop, out_valid;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      subtract_q <= 1'b0;
      transpose_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCALE:     scale_q <= $signed(cfg_data_i[VAL_W-1:0]);
        REG_SUBTRACT:  subtract_q <= cfg_data_i[0];
        REG_TRANSPOSE: transpose_q <= cfg_data_i[0];
        default:       scale_q <= scale_q;
      endcase
    end
  end

  smva_front #(.VectorDepth(VectorDepth)) u_front (
    .clk_i,
    .rst_ni,
    .transpose_i(transpose_q),
    .push_i     (push),
    .in_item_i,
    .full_o     (full),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  smva_back #(.VectorDepth(VectorDepth)) u_back (
    .clk_i,
    .rst_ni,
    .scale_i    (scale_q),
    .subtract_i (subtract_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid),
    .out_item_o,
    .out_pop_i  (pop && out_valid)
  );

  assign empty = !out_valid;

endmodule

[rtl/smva_ram.sv]
module smva_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/smva_front.sv]
module smva_front
  import smva_pkg::*;
#(
  parameter int unsigned VectorDepth = VECTOR_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     transpose_i,
  input  logic     push_i,
  input  in_item_t in_item_i,
  output logic     full_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  logic idx_ok, col_ok, keep, enq, deq;
  cmd_t cmd_new;

  // classify the item
  always_comb begin
    idx_ok = 32'(in_item_i.first_index) < 32'(VectorDepth);
    col_ok = 32'(in_item_i.column_index) < 32'(VectorDepth);
    cmd_new.idx_ok = idx_ok;
    cmd_new.data = in_item_i.data_value;
    cmd_new.src = in_item_i.column_index;
    cmd_new.dst = in_item_i.first_index;
    cmd_new.op = OP_READ;
    keep = 1'b0;
    unique case (in_item_i.req_type)
      REQ_LOAD_VEC: begin
        cmd_new.op = OP_VEC_WR;
        keep = idx_ok;
      end
      REQ_LOAD_RES: begin
        cmd_new.op = OP_RES_WR;
        keep = idx_ok;
      end
      REQ_NONZERO: begin
        cmd_new.op = OP_NONZERO;
        keep = idx_ok && col_ok;
        if (transpose_i) begin
          cmd_new.src = in_item_i.first_index;
          cmd_new.dst = in_item_i.column_index;
        end
      end
      REQ_READ: begin
        cmd_new.op = OP_READ;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o = queue_q[rd_ptr_q];

  assign enq = push_i && !full_o && keep;
  assign deq = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d = count_q + QCNT_W'(enq) - QCNT_W'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[rtl/smva_back.sv]
module smva_back
  import smva_pkg::*;
#(
  parameter int unsigned VectorDepth = VECTOR_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [VAL_W-1:0] scale_i,
  input  logic                    subtract_i,
  input  logic                    cmd_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  output out_item_t               out_item_o,
  input  logic                    out_pop_i
);

  localparam int unsigned AddrW = $clog2(VectorDepth);

  st_e state_q, state_d;
  cmd_t cmd_q, cmd_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic out_valid_q;
  out_item_t out_item_q;

  logic signed [VAL_W-1:0] mul_a, mul_b, prod_sat, res_new;
  logic signed [VAL_W:0] acc;
  logic out_load;

  logic vec_we, vec_re, res_we, res_re;
  logic [AddrW-1:0] vec_waddr, vec_raddr, res_waddr, res_raddr;
  logic [VAL_W-1:0] vec_wdata, vec_rdata, res_wdata, res_rdata;

  smva_ram #(.Width(VAL_W), .Depth(VectorDepth)) u_vec_ram (
    .clk_i,
    .we_i   (vec_we),
    .waddr_i(vec_waddr),
    .wdata_i(vec_wdata),
    .re_i   (vec_re),
    .raddr_i(vec_raddr),
    .rdata_o(vec_rdata)
  );

  smva_ram #(.Width(VAL_W), .Depth(VectorDepth)) u_res_ram (
    .clk_i,
    .we_i   (res_we),
    .waddr_i(res_waddr),
    .wdata_i(res_wdata),
    .re_i   (res_re),
    .raddr_i(res_raddr),
    .rdata_o(res_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_NONZERO: state_d = ST_MUL1;
            OP_READ:    state_d = ST_READ;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (!out_valid_q || out_pop_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // shared multiplier and saturation
  always_comb begin
    prod_sat = sat_q(prod_q[PROD_W-1:FRAC_W]);
    if (state_q == ST_IDLE) begin
      mul_a = scale_i;
      mul_b = cmd_i.data;
    end else begin
      mul_a = prod_sat;
      mul_b = $signed(vec_rdata);
    end
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
    acc = subtract_i ? (VAL_W+1)'($signed(res_rdata)) - (VAL_W+1)'(prod_sat)
                     : (VAL_W+1)'($signed(res_rdata)) + (VAL_W+1)'(prod_sat);
    res_new = sat_q((PROD_W-FRAC_W)'(acc));
  end

  // outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    cmd_d = cmd_q;
    vec_we = 1'b0;
    vec_re = 1'b0;
    res_we = 1'b0;
    res_re = 1'b0;
    vec_waddr = AddrW'(cmd_i.dst);
    vec_wdata = cmd_i.data;
    vec_raddr = AddrW'(cmd_i.src);
    res_waddr = AddrW'(cmd_i.dst);
    res_wdata = cmd_i.data;
    res_raddr = AddrW'(cmd_i.dst);
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.op)
            OP_VEC_WR:  vec_we = 1'b1;
            OP_RES_WR:  res_we = 1'b1;
            OP_NONZERO: vec_re = 1'b1;
            OP_READ:    res_re = cmd_i.idx_ok;
            default:    cmd_pop_o = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_load = !out_valid_q || out_pop_i;
      end
      ST_MUL1: begin
        res_re = 1'b1;
        res_raddr = AddrW'(cmd_q.dst);
      end
      ST_MUL2: begin
        res_we = 1'b1;
        res_waddr = AddrW'(cmd_q.dst);
        res_wdata = res_new;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    prod_q <= prod_d;
    if (out_load) begin
      out_item_q.out_index <= cmd_q.dst;
      out_item_q.out_value <= cmd_q.idx_ok ? $signed(res_rdata) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

endmodule

[rtl/smva_checker.sv]
module smva_checker
  import smva_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> (empty && !full))
    else $error("queues not drained after reset");

  // the command queue fills only through accepted items
  a_full_by_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed");

endmodule

bind sparse_matrix_vector_accumulate smva_checker u_smva_checker (.*);

[tb/smva_product_check.sv]
module smva_product_check
  import smva_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  in_item_t              in_item_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic signed [VAL_W-1:0] operand_mem [VECTOR_DEPTH_DEF];
  logic signed [VAL_W-1:0] accum_mem [VECTOR_DEPTH_DEF];
  logic signed [VAL_W-1:0] scale_q = SCALE_RESET;
  logic subtract_q = 1'b0;
  logic transpose_q = 1'b0;
  out_item_t read_values [$];
  int mismatches = 0;
  int waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o = waiting;

  function automatic logic signed [VAL_W-1:0] clamp_q16(longint x);
    if (x > longint'(VAL_MAX)) begin
      return VAL_MAX;
    end
    if (x < longint'(VAL_MIN)) begin
      return VAL_MIN;
    end
    return x[VAL_W-1:0];
  endfunction

  // q16.16 product, floored and saturated
  function automatic logic signed [VAL_W-1:0] q16_product(logic signed [VAL_W-1:0] a,
                                                          logic signed [VAL_W-1:0] b);
    longint full_prod;
    full_prod = longint'(a) * longint'(b);
    return clamp_q16(full_prod >>> FRAC_W);
  endfunction

  task automatic report_failure(string text);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", text);
    end
  endtask

  task automatic apply_request(in_item_t it);
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic signed [VAL_W-1:0] coeff;
    logic signed [VAL_W-1:0] term;
    longint sum;
    out_item_t want;
    case (it.req_type)
      REQ_LOAD_VEC: begin
        operand_mem[it.first_index] = it.data_value;
      end
      REQ_LOAD_RES: begin
        accum_mem[it.first_index] = it.data_value;
      end
      REQ_NONZERO: begin
        if (transpose_q) begin
          src = it.first_index;
          dst = it.column_index;
        end else begin
          src = it.column_index;
          dst = it.first_index;
        end
        coeff = q16_product(scale_q, it.data_value);
        term = q16_product(coeff, operand_mem[src]);
        if (subtract_q) begin
          sum = longint'(accum_mem[dst]) - longint'(term);
        end else begin
          sum = longint'(accum_mem[dst]) + longint'(term);
        end
        accum_mem[dst] = clamp_q16(sum);
      end
      default: begin
        want.out_index = it.first_index;
        want.out_value = accum_mem[it.first_index];
        read_values.push_back(want);
      end
    endcase
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (read_values.size() == 0) begin
      report_failure($sformatf("unexpected result: index %0d value %0d",
                               got.out_index, got.out_value));
    end else begin
      want = read_values.pop_front();
      if (got.out_index !== want.out_index || got.out_value !== want.out_value) begin
        report_failure($sformatf("result mismatch: expected index %0d value %0d, got index %0d value %0d",
                                 want.out_index, want.out_value, got.out_index, got.out_value));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q = SCALE_RESET;
      subtract_q = 1'b0;
      transpose_q = 1'b0;
      read_values.delete();
      waiting = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCALE: scale_q = cfg_data_i;
          REG_SUBTRACT: subtract_q = cfg_data_i[0];
          REG_TRANSPOSE: transpose_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        check_result(out_item_i);
      end
      if (push_i && !full_i) begin
        apply_request(in_item_i);
      end
      waiting = read_values.size();
    end
  end

endmodule

[tb/sparse_matrix_vector_accumulate_tb.sv]
module sparse_matrix_vector_accumulate_tb;
  import smva_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseCount = 22;
  localparam int PhaseItems = 20;
  localparam int SettleCycles = 32;
  localparam int HoldCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count;
  int pending;

  bit vec_seen [VECTOR_DEPTH_DEF];
  bit res_seen [VECTOR_DEPTH_DEF];
  int vec_list [$];
  int res_list [$];
  int hot_index [16];
  int corner_values [7] = '{32'h7fffffff, 32'h80000000, 0, 1, -1, 65536, -65536};
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit transpose_on = 1'b0;
  int read_share = 20;
  int last_dst = -1;
  int cycles = 0;

  sparse_matrix_vector_accumulate DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  smva_product_check product_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sparse_matrix_vector_accumulate verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(req_e req, int first, int column, int value);
    in_item_t it;
    it.req_type = req;
    it.first_index = first[IDX_W-1:0];
    it.column_index = column[IDX_W-1:0];
    it.data_value = value;
    return it;
  endfunction

  function automatic int rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return corner_values[$urandom_range(0, 6)];
    end
    if (pick < 4) begin
      return int'($urandom());
    end
    return int'($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  function automatic int pick_index();
    if ($urandom_range(0, 3) != 0) begin
      return hot_index[$urandom_range(0, 15)];
    end
    return int'($urandom_range(0, VECTOR_DEPTH_DEF - 1));
  endfunction

  function automatic int any_col();
    return int'($urandom_range(0, VECTOR_DEPTH_DEF - 1));
  endfunction

  function automatic logic signed [VAL_W-1:0] scale_pick();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return SCALE_RESET;
      4: return -SCALE_RESET;
      5: return $urandom();
      default: return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  // only entries already written are used as sources, targets or reads
  function automatic in_item_t random_item();
    int src;
    int dst;
    if (res_list.size() != 0 && $urandom_range(0, 99) < read_share) begin
      return make_item(REQ_READ, res_list[$urandom_range(0, res_list.size() - 1)],
                       any_col(), rand_value());
    end
    case ($urandom_range(0, 4))
      0: return make_item(REQ_LOAD_VEC, pick_index(), any_col(), rand_value());
      1: return make_item(REQ_LOAD_RES, pick_index(), any_col(), rand_value());
      default: begin
        if (vec_list.size() == 0 || res_list.size() == 0) begin
          return make_item(REQ_LOAD_VEC, pick_index(), any_col(), rand_value());
        end
        src = vec_list[$urandom_range(0, vec_list.size() - 1)];
        if (last_dst >= 0 && $urandom_range(0, 2) == 0) begin
          dst = last_dst;
        end else begin
          dst = res_list[$urandom_range(0, res_list.size() - 1)];
        end
        last_dst = dst;
        if (transpose_on) begin
          return make_item(REQ_NONZERO, src, dst, rand_value());
        end
        return make_item(REQ_NONZERO, dst, src, rand_value());
      end
    endcase
  endfunction

  task automatic push_item(in_item_t it);
    if (it.req_type == REQ_LOAD_VEC && !vec_seen[it.first_index]) begin
      vec_seen[it.first_index] = 1'b1;
      vec_list.push_back(int'(it.first_index));
    end
    if (it.req_type == REQ_LOAD_RES && !res_seen[it.first_index]) begin
      res_seen[it.first_index] = 1'b1;
      res_list.push_back(int'(it.first_index));
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic write_config(logic signed [VAL_W-1:0] scale, bit sub, bit tr);
    cfg_we <= 1'b1;
    cfg_idx <= REG_SCALE;
    cfg_data <= scale;
    @(negedge clk_i);
    cfg_idx <= REG_SUBTRACT;
    cfg_data <= CFG_DATA_W'(sub);
    @(negedge clk_i);
    cfg_idx <= REG_TRANSPOSE;
    cfg_data <= CFG_DATA_W'(tr);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    transpose_on = tr;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    @(negedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    int n;
    rst_ni = 1'b0;
    for (int i = 0; i < 16; i++) begin
      hot_index[i] = $urandom_range(0, VECTOR_DEPTH_DEF - 1);
    end
    hot_index[0] = 0;
    hot_index[1] = 1023;
    hot_index[2] = 10'h155;
    hot_index[3] = 10'h2aa;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, extreme operands and saturation
    push_item(make_item(REQ_LOAD_VEC, 0, any_col(), 32'h0001_0000));
    push_item(make_item(REQ_LOAD_VEC, 1023, any_col(), 32'h7fff_ffff));
    push_item(make_item(REQ_LOAD_VEC, 5, any_col(), 32'h8000_0000));
    push_item(make_item(REQ_LOAD_RES, 0, any_col(), 0));
    push_item(make_item(REQ_LOAD_RES, 1023, any_col(), 32'h7fff_ffff));
    push_item(make_item(REQ_LOAD_RES, 5, any_col(), 32'h8000_0000));
    push_item(make_item(REQ_LOAD_RES, 512, any_col(), 32'h1234_5678));
    push_item(make_item(REQ_READ, 1023, any_col(), rand_value()));
    push_item(make_item(REQ_NONZERO, 0, 0, 32'h0001_0000));
    push_item(make_item(REQ_NONZERO, 0, 1023, 32'h7fff_ffff));
    push_item(make_item(REQ_NONZERO, 1023, 5, 32'h8000_0000));
    push_item(make_item(REQ_NONZERO, 5, 5, 1));
    // negative fraction coefficients, same target back to back
    push_item(make_item(REQ_NONZERO, 512, 0, 32'hffff_8000));
    push_item(make_item(REQ_NONZERO, 512, 0, 32'hffff_8000));
    push_item(make_item(REQ_READ, 0, any_col(), rand_value()));
    push_item(make_item(REQ_READ, 5, any_col(), rand_value()));
    push_item(make_item(REQ_READ, 512, any_col(), rand_value()));
    push_item(make_item(REQ_READ, 1023, any_col(), rand_value()));
    settle();

    write_config(VAL_MIN, 1'b1, 1'b1);
    push_item(make_item(REQ_LOAD_RES, 1023, any_col(), 0));
    push_item(make_item(REQ_NONZERO, 0, 1023, 32'h0001_0000));
    push_item(make_item(REQ_NONZERO, 5, 0, 32'hffff_0000));
    push_item(make_item(REQ_READ, 1023, any_col(), rand_value()));
    push_item(make_item(REQ_READ, 0, any_col(), rand_value()));
    settle();

    write_config(VAL_MAX, 1'b0, 1'b0);
    push_item(make_item(REQ_NONZERO, 5, 1023, 32'h0001_0000));
    push_item(make_item(REQ_READ, 5, any_col(), rand_value()));
    settle();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      quiet = (ph >= PhaseCount - 4) || ($urandom_range(0, 3) == 0);
      read_share = 20;
      n = PhaseItems;
      if (ph == 2) begin
        // results held back while reads keep coming, so the input side backs up
        quiet = 1'b1;
        read_share = 95;
        n = 40;
        long_hold = 1'b1;
      end
      write_config(scale_pick(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      last_dst = -1;
      repeat (n) push_item(random_item());
      push_item(make_item(REQ_READ, res_list[$urandom_range(0, res_list.size() - 1)],
                          any_col(), rand_value()));
      settle();
    end

    if (fail_count == 0) begin
      $display("sparse_matrix_vector_accumulate verification clean");
    end else begin
      $display("sparse_matrix_vector_accumulate verification failed");
    end
    $finish;
  end

endmodule

[sparse_matrix_vector_accumulate.f]
rtl/smva_pkg.sv
rtl/smva_ram.sv
rtl/smva_front.sv
rtl/smva_back.sv
rtl/sparse_matrix_vector_accumulate.sv
rtl/smva_checker.sv
tb/smva_product_check.sv
tb/sparse_matrix_vector_accumulate_tb.sv
